FILE: design/mpdc_pkg.sv
// ----------------------------------------------------------------------------
// Motor PWM duty controller package
// Shared widths, constants, state encoding, unit request types and the
// supply voltage drive factor function.
// ----------------------------------------------------------------------------
package mpdc_pkg;

    localparam int SPD_W       = 16;
    localparam int VADC_W      = 8;
    localparam int CADC_W      = 16;
    localparam int TIME_W      = 31;
    localparam int DUTY_W      = 16;
    localparam int K_W         = 8;
    localparam int D_W         = 23;
    localparam int LIM_W       = 17;
    localparam int MCAND_W     = 23;
    localparam int MPLIER_W    = 17;
    localparam int PROD_W      = MCAND_W + MPLIER_W;
    localparam int DIV_CNT_W   = 5;
    localparam int FPROD_W     = 30;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DUTY_W - 1;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int CFG_W       = 16;

    localparam logic [DUTY_W-1:0]    DUTY_FULL_SCALE   = 16'hFFFF;
    localparam logic [CFG_W-1:0]     RST_MAX_SPEED_ERR = 16'hFFFF;
    localparam logic [CFG_W-1:0]     RST_STALL_SPEED   = 16'd10;
    localparam logic [CFG_W-1:0]     RST_STALL_DEMAND  = 16'd20;
    localparam logic [CFG_W-1:0]     RST_STALL_TIME    = 16'd1000;

    localparam logic [VADC_W-1:0]    VOLT_CUTOFF       = 8'd132;
    localparam logic [K_W-1:0]       K_BASE            = 8'd170;
    localparam logic [11:0]          VOLT_NUM          = 12'd22;
    localparam logic [23:0]          VOLT_RECIP        = 24'd3856;
    localparam logic [MCAND_W-1:0]   SENSE_SCALE       = 23'd216269;
    localparam logic [CADC_W-1:0]    CADC_CLAMP        = 16'd19860;
    localparam logic [LIM_W-1:0]     LIM_FULL          = 17'h10000;
    localparam logic [16:0]          SENSE_DIV         = 17'd65535;
    localparam logic [12:0]          FILT_NEW          = 13'd1311;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS         = 5'd16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_K_GO,
        S_K_WAIT,
        S_SN_GO,
        S_SN_WAIT,
        S_LIM_GO,
        S_LIM_WAIT,
        S_FILT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        REG_MAX_SPEED_ERR,
        REG_STALL_SPEED,
        REG_STALL_DEMAND,
        REG_STALL_TIME
    } t_reg_idx;

    typedef struct packed {
        logic                start;
        logic [MCAND_W-1:0]  mcand;
        logic [MPLIER_W-1:0] mplier;
    } t_mul_req;

    typedef struct packed {
        logic             start;
        logic [SPD_W-1:0] hi;
        logic [SPD_W-1:0] lo;
        logic [SPD_W-1:0] divisor;
    } t_div_req;

    // Drive factor 170 - floor(330 * v / 255), zero once the supply is too high.
    function automatic logic [K_W-1:0] f_drive_k(input logic [VADC_W-1:0] v);
        logic [11:0]    x;
        logic [23:0]    p;
        logic [K_W-1:0] volt;
        x    = 12'(v) * VOLT_NUM;
        p    = 24'(x) * VOLT_RECIP;
        volt = p[23:16];
        if (v >= VOLT_CUTOFF) begin
            f_drive_k = '0;
        end else begin
            f_drive_k = K_BASE - volt;
        end
    endfunction

endpackage

FILE: design/mpdc_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add over one multiplier bit per cycle, stopping as soon as the
// remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module mpdc_mul import mpdc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mul_req          i_req,
    output logic              o_done,
    output logic [PROD_W-1:0] o_product
);

    logic                r_busy;
    logic                n_busy;
    logic [PROD_W-1:0]   r_acc;
    logic [PROD_W-1:0]   n_acc;
    logic [PROD_W-1:0]   r_mcand;
    logic [PROD_W-1:0]   n_mcand;
    logic [MPLIER_W-1:0] r_mplier;
    logic [MPLIER_W-1:0] n_mplier;

    assign o_done    = r_busy && (r_mplier == '0);
    assign o_product = r_acc;

    always_comb begin
        n_busy   = r_busy;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        if (i_req.start) begin
            n_busy   = 1'b1;
            n_acc    = '0;
            n_mcand  = PROD_W'(i_req.mcand);
            n_mplier = i_req.mplier;
        end else if (o_done) begin
            n_busy = 1'b0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

endmodule

FILE: design/mpdc_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division of a 32-bit dividend by a 16-bit divisor, one quotient
// bit per cycle; the upper dividend half must be below the divisor.
// ----------------------------------------------------------------------------
module mpdc_div import mpdc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [SPD_W-1:0]  o_quotient
);

    logic                 r_busy;
    logic                 n_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_CNT_W-1:0] n_cnt;
    logic [SPD_W-1:0]     r_rem;
    logic [SPD_W-1:0]     n_rem;
    logic [SPD_W-1:0]     r_quo;
    logic [SPD_W-1:0]     n_quo;
    logic [SPD_W-1:0]     r_divisor;
    logic [SPD_W-1:0]     n_divisor;
    logic [SPD_W:0]       rem_sh;
    logic                 fits;

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_quo;
    assign rem_sh     = {r_rem, r_quo[SPD_W-1]};
    assign fits       = rem_sh >= {1'b0, r_divisor};

    always_comb begin
        n_busy    = r_busy;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_divisor = r_divisor;
        if (i_req.start) begin
            n_busy    = 1'b1;
            n_cnt     = DIV_STEPS;
            n_rem     = i_req.hi;
            n_quo     = i_req.lo;
            n_divisor = i_req.divisor;
        end else if (o_done) begin
            n_busy = 1'b0;
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            n_rem = fits ? SPD_W'(rem_sh - {1'b0, r_divisor}) : rem_sh[SPD_W-1:0];
            n_quo = {r_quo[SPD_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_divisor <= n_divisor;
    end

endmodule

FILE: design/motor_pwm_duty_controller_core.sv
// ----------------------------------------------------------------------------
// Motor PWM duty controller core
// An accepted input transaction reaches the output register after the bit-serial
// divider (16 steps, only when the ratio needs it) and the shared bit-serial
// multiplier (up to 8, 16 and 17 steps).
// Throughput: one transaction at a time; the next input can be taken in the cycle
// after the result is registered, even while that result waits.
// Reset is synchronous and active low; it restores the register defaults,
// clears the stall fault, stall timer, filter and output valid.
// ----------------------------------------------------------------------------
module motor_pwm_duty_controller_core import mpdc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // desired_speed, measured_speed, voltage_adc, current_adc, run_switch, time_ms
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // duty, stall_fault, zero padding
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]    r_max_err;
    logic [CFG_W-1:0]    r_stall_speed;
    logic [CFG_W-1:0]    r_stall_demand;
    logic [CFG_W-1:0]    r_stall_time;

    logic [SPD_W-1:0]    r_des;
    logic [SPD_W-1:0]    r_meas;
    logic [VADC_W-1:0]   r_vadc;
    logic [CADC_W-1:0]   r_cadc;
    logic                r_run;
    logic [TIME_W-1:0]   r_now;

    logic [SPD_W-1:0]    r_raw;
    logic [K_W-1:0]      r_k;
    logic [D_W-1:0]      r_d;
    logic [LIM_W-1:0]    r_lim;
    logic [DUTY_W-1:0]   r_d16;
    logic signed [FPROD_W-1:0] r_fprod;

    logic                r_fault;
    logic                n_fault;
    logic                r_active;
    logic                n_active;
    logic [TIME_W-1:0]   r_start_time;
    logic [TIME_W-1:0]   n_start_time;
    logic [DUTY_W-1:0]   r_filt;

    logic                r_m_valid;
    logic [DUTY_W-1:0]   r_m_duty;
    logic                r_m_fault;

    t_mul_req            mul_req;
    logic                mul_done;
    logic [PROD_W-1:0]   mul_product;
    t_div_req            div_req;
    logic                div_done;
    logic [SPD_W-1:0]    div_quotient;

    logic                in_acc;
    logic                out_load;
    logic                cfg_wr;
    logic [SPD_W-1:0]    err_wrap;
    logic [SPD_W-1:0]    err;
    logic [31:0]         dividend;
    logic                need_div;
    logic [SPD_W-1:0]    sense_q0;
    logic [16:0]         sense_rem;
    logic [SPD_W-1:0]    sense;
    logic [LIM_W-1:0]    lim_calc;
    logic [PROD_W-17:0]  d_hi;
    logic [DUTY_W-1:0]   d_sat;
    logic [TIME_W-1:0]   elapsed;
    logic [DUTY_W-1:0]   d_gated;
    logic signed [DUTY_W:0]   filt_diff;
    logic signed [DUTY_W+1:0] filt_sum;

    mpdc_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mul_req),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    mpdc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (r_state == S_DONE) && (!r_m_valid || m_tready);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign m_tvalid = r_m_valid;
    assign m_tdata  = {OUT_PAD_W'(0), r_m_fault, r_m_duty};

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_MAX_SPEED_ERR: prdata = APB_DATA_W'(r_max_err);
            REG_STALL_SPEED:   prdata = APB_DATA_W'(r_stall_speed);
            REG_STALL_DEMAND:  prdata = APB_DATA_W'(r_stall_demand);
            REG_STALL_TIME:    prdata = APB_DATA_W'(r_stall_time);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_err      <= RST_MAX_SPEED_ERR;
            r_stall_speed  <= RST_STALL_SPEED;
            r_stall_demand <= RST_STALL_DEMAND;
            r_stall_time   <= RST_STALL_TIME;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_MAX_SPEED_ERR: r_max_err      <= pwdata[CFG_W-1:0];
                REG_STALL_SPEED:   r_stall_speed  <= pwdata[CFG_W-1:0];
                REG_STALL_DEMAND:  r_stall_demand <= pwdata[CFG_W-1:0];
                REG_STALL_TIME:    r_stall_time   <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Speed error and the dividend 65535 * err for the duty ratio.
    always_comb begin
        err_wrap = r_des - r_meas;
        err      = (err_wrap > r_max_err) ? '0 : err_wrap;
        dividend = {err, 16'h0000} - 32'(err);
        need_div = (err != '0) && (err < r_des);
    end

    // Current limit and duty saturation: sense = floor(x / 65535) with x below 2^32.
    always_comb begin
        sense_q0  = mul_product[31:16];
        sense_rem = 17'(mul_product[15:0]) + 17'(sense_q0);
        sense     = sense_q0 + SPD_W'(sense_rem >= SENSE_DIV);
        lim_calc  = (r_cadc >= CADC_CLAMP) ? '0 : LIM_FULL - LIM_W'(sense);
        d_hi      = mul_product[PROD_W-1:16];
        d_sat     = (d_hi[PROD_W-17:DUTY_W] != '0) ? DUTY_FULL_SCALE : d_hi[DUTY_W-1:0];
    end

    // Stall timing, gating of the duty ahead of the filter and the filter update terms.
    always_comb begin
        n_fault      = r_fault;
        n_active     = r_active;
        n_start_time = r_start_time;
        elapsed      = r_now - r_start_time;
        if (r_run && !r_fault) begin
            if ((r_meas <= r_stall_speed) && (r_des > r_stall_demand)) begin
                if (!r_active) begin
                    n_active     = 1'b1;
                    n_start_time = r_now;
                end else if (elapsed > TIME_W'(r_stall_time)) begin
                    n_fault = 1'b1;
                end
            end else begin
                n_active = 1'b0;
            end
        end
        d_gated   = (n_fault || !r_run) ? '0 : r_d16;
        filt_diff = $signed({1'b0, d_gated}) - $signed({1'b0, r_filt});
        filt_sum  = $signed({2'b00, r_filt}) + $signed(r_fprod[FPROD_W-1:16]);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (s_tvalid) n_state = S_PREP;
            S_PREP:     n_state = need_div ? S_DIV : S_K_GO;
            S_DIV:      if (div_done) n_state = S_K_GO;
            S_K_GO:     n_state = S_K_WAIT;
            S_K_WAIT:   if (mul_done) n_state = S_SN_GO;
            S_SN_GO:    n_state = S_SN_WAIT;
            S_SN_WAIT:  if (mul_done) n_state = S_LIM_GO;
            S_LIM_GO:   n_state = S_LIM_WAIT;
            S_LIM_WAIT: if (mul_done) n_state = S_FILT;
            S_FILT:     n_state = S_DONE;
            S_DONE:     if (!r_m_valid || m_tready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        mul_req         = '0;
        div_req.start   = 1'b0;
        div_req.hi      = dividend[31:16];
        div_req.lo      = dividend[15:0];
        div_req.divisor = r_des;
        case (r_state)
            S_IDLE: begin
                s_tready = 1'b1;
            end
            S_PREP: begin
                div_req.start = need_div;
            end
            S_K_GO: begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = MCAND_W'(r_raw);
                mul_req.mplier = MPLIER_W'(r_k);
            end
            S_SN_GO: begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = SENSE_SCALE;
                mul_req.mplier = MPLIER_W'(r_cadc);
            end
            S_LIM_GO: begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = r_d;
                mul_req.mplier = r_lim;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fault      <= 1'b0;
            r_active     <= 1'b0;
            r_start_time <= '0;
            r_filt       <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FILT) begin
                r_fault      <= n_fault;
                r_active     <= n_active;
                r_start_time <= n_start_time;
            end
            if (out_load) begin
                r_filt    <= filt_sum[DUTY_W-1:0];
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_des  <= s_tdata[15:0];
            r_meas <= s_tdata[31:16];
            r_vadc <= s_tdata[39:32];
            r_cadc <= s_tdata[55:40];
            r_run  <= s_tdata[56];
            r_now  <= s_tdata[87:57];
        end
        if (r_state == S_PREP) begin
            r_raw <= (err == '0) ? '0 : DUTY_FULL_SCALE;
            r_k   <= f_drive_k(r_vadc);
        end
        if ((r_state == S_DIV) && div_done) begin
            r_raw <= div_quotient;
        end
        if ((r_state == S_K_WAIT) && mul_done) begin
            r_d <= mul_product[D_W:1];
        end
        if ((r_state == S_SN_WAIT) && mul_done) begin
            r_lim <= lim_calc;
        end
        if ((r_state == S_LIM_WAIT) && mul_done) begin
            r_d16 <= d_sat;
        end
        if (r_state == S_FILT) begin
            r_fprod <= filt_diff * $signed(FILT_NEW);
        end
        if (out_load) begin
            r_m_duty  <= filt_sum[DUTY_W-1:0];
            r_m_fault <= r_fault;
        end
    end

    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |=> r_fault)
        else $error("stall fault cleared without reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a transaction is in progress");

    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    a_flag_matches_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (!m_tdata[DUTY_W] || r_fault))
        else $error("reported stall fault without a latched fault");

endmodule

FILE: verif/mpdc_checker.sv
// ----------------------------------------------------------------------------
// Motor PWM duty controller checker
// Watches the input, output and register ports of the duty controller. Each
// input transaction is run through a cycle-free model of the duty law and the
// stall fault timer, and the expected result is queued. Each output
// transaction is compared field by field with the oldest queued result.
// Register reads are compared with the register values written so far.
// ----------------------------------------------------------------------------
module mpdc_checker import mpdc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // desired_speed, measured_speed, voltage_adc, current_adc, run_switch, time_ms
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // duty, stall_fault, zero padding
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    input  logic [APB_DATA_W-1:0]  prdata,
    input  logic                   pready,
    output int                     o_pending,
    output int                     o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic              run_switch;
        logic [CADC_W-1:0] current_adc;
        logic [VADC_W-1:0] voltage_adc;
        logic [SPD_W-1:0]  measured_speed;
        logic [SPD_W-1:0]  desired_speed;
    } t_tick;

    localparam longint unsigned FULL      = 65535;
    localparam longint unsigned LP_GAIN   = 1311;
    localparam longint unsigned SENSE_Q16 = 216269;

    logic [CFG_W-1:0]       lim_err;
    logic [CFG_W-1:0]       stop_speed;
    logic [CFG_W-1:0]       stop_demand;
    logic [CFG_W-1:0]       stop_time;
    logic                   fault_hold;
    logic                   stop_timer_on;
    logic [TIME_W-1:0]      stop_t0;
    logic [DUTY_W-1:0]      duty_lp;
    logic [OUT_TDATA_W-1:0] duty_results_due[$];
    int                     mismatch_total = 0;

    function automatic logic [63:0] clip_full(input logic [63:0] v);
        return (v > FULL) ? FULL : v;
    endfunction

    function automatic logic [OUT_TDATA_W-1:0] next_duty_and_fault(input t_tick t);
        logic [SPD_W-1:0]  err;
        logic [63:0]       d;
        logic [63:0]       sense;
        logic [63:0]       lim;
        int unsigned       volt;
        logic [TIME_W-1:0] elapsed;
        err = t.desired_speed - t.measured_speed;
        if (err > lim_err) begin
            err = '0;
        end
        if (t.desired_speed == '0) begin
            d = (err != '0) ? FULL : 64'd0;
        end else begin
            d = clip_full(FULL * err / t.desired_speed);
        end
        volt = (330 * t.voltage_adc) / 255;
        if (volt >= 170) begin
            d = '0;
        end else begin
            d = d * (170 - volt) / 2;
        end
        sense = 64'(t.current_adc) * SENSE_Q16 / FULL;
        lim   = (sense >= 64'd65536) ? 64'd0 : 64'd65536 - sense;
        d     = clip_full((d * lim) >> 16);
        if (t.run_switch && !fault_hold) begin
            if (t.measured_speed <= stop_speed && t.desired_speed > stop_demand) begin
                if (!stop_timer_on) begin
                    stop_timer_on = 1'b1;
                    stop_t0       = t.time_ms;
                end else begin
                    elapsed = t.time_ms - stop_t0;
                    if (elapsed > stop_time) begin
                        fault_hold = 1'b1;
                    end
                end
            end else begin
                stop_timer_on = 1'b0;
            end
        end
        if (fault_hold || !t.run_switch) begin
            d = '0;
        end
        duty_lp = DUTY_W'((LP_GAIN * d + (64'd65536 - LP_GAIN) * duty_lp) >> 16);
        return {{OUT_PAD_W{1'b0}}, fault_hold, duty_lp};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mpdc_checker: %s", $time, msg);
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin : watch
        logic [OUT_TDATA_W-1:0] want;
        logic [CFG_W-1:0]       reg_now;
        if (!i_rst_n) begin
            lim_err       = RST_MAX_SPEED_ERR;
            stop_speed    = RST_STALL_SPEED;
            stop_demand   = RST_STALL_DEMAND;
            stop_time     = RST_STALL_TIME;
            fault_hold    = 1'b0;
            stop_timer_on = 1'b0;
            stop_t0       = '0;
            duty_lp       = '0;
            duty_results_due.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (t_reg_idx'(paddr[3:2]))
                        REG_MAX_SPEED_ERR: lim_err     = pwdata[CFG_W-1:0];
                        REG_STALL_SPEED:   stop_speed  = pwdata[CFG_W-1:0];
                        REG_STALL_DEMAND:  stop_demand = pwdata[CFG_W-1:0];
                        REG_STALL_TIME:    stop_time   = pwdata[CFG_W-1:0];
                        default: ;
                    endcase
                end else begin
                    case (t_reg_idx'(paddr[3:2]))
                        REG_MAX_SPEED_ERR: reg_now = lim_err;
                        REG_STALL_SPEED:   reg_now = stop_speed;
                        REG_STALL_DEMAND:  reg_now = stop_demand;
                        default:           reg_now = stop_time;
                    endcase
                    if (prdata !== {{(APB_DATA_W-CFG_W){1'b0}}, reg_now}) begin
                        report_mismatch($sformatf("read of 0x%0h got 0x%0h want 0x%0h",
                            paddr, prdata, reg_now));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                duty_results_due.push_back(next_duty_and_fault(t_tick'(s_tdata)));
            end
            if (m_tvalid && m_tready) begin
                if (duty_results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected output transaction 0x%0h", m_tdata));
                end else begin
                    want = duty_results_due.pop_front();
                    if (m_tdata[DUTY_W-1:0] !== want[DUTY_W-1:0]) begin
                        report_mismatch($sformatf("duty got %0d want %0d",
                            m_tdata[DUTY_W-1:0], want[DUTY_W-1:0]));
                    end
                    if (m_tdata[DUTY_W] !== want[DUTY_W]) begin
                        report_mismatch($sformatf("stall_fault got %b want %b",
                            m_tdata[DUTY_W], want[DUTY_W]));
                    end
                    if (m_tdata[OUT_TDATA_W-1:DUTY_W+1] !== '0) begin
                        report_mismatch($sformatf("padding got 0x%0h",
                            m_tdata[OUT_TDATA_W-1:DUTY_W+1]));
                    end
                end
            end
        end
        o_pending <= duty_results_due.size();
        o_errors  <= mismatch_total;
    end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Motor PWM duty controller testbench
// Drives control ticks into the duty controller and sets its registers over
// the APB port between phases. A directed set of ticks covers zero demand,
// wrapped speed error, the supply voltage cutoff, the current limit, the open
// run switch and stall timing across the time wrap. Random phases follow under
// several register settings, with stall sequences whose stopped time stays
// within the limit, and a last phase drives the stall fault to latch. Both
// stream sides idle in random bursts. The checker instance judges results.
// ----------------------------------------------------------------------------
module tb_top import mpdc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic              run_switch;
        logic [CADC_W-1:0] current_adc;
        logic [VADC_W-1:0] voltage_adc;
        logic [SPD_W-1:0]  measured_speed;
        logic [SPD_W-1:0]  desired_speed;
    } t_tick;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    int                     pending;
    int                     errors;

    bit                     no_idle  = 1'b0;
    int                     stall_left = 0;
    int unsigned            st_speed;
    int unsigned            st_demand;
    int unsigned            st_time;
    logic [TIME_W-1:0]      now_ms   = '0;
    int unsigned            used_ms  = 0;

    always #5 i_clk = ~i_clk;

    motor_pwm_duty_controller_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mpdc_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_pending (pending),
        .o_errors  (errors)
    );

    always @(posedge i_clk) begin
        logic ready_next;
        if (no_idle || !i_rst_n) begin
            ready_next = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
        end
        m_tready <= ready_next;
    end

    function automatic t_tick mk(input int unsigned des, input int unsigned meas,
                                 input int unsigned v, input int unsigned c,
                                 input bit run, input logic [TIME_W-1:0] tm);
        t_tick t;
        t.desired_speed  = SPD_W'(des);
        t.measured_speed = SPD_W'(meas);
        t.voltage_adc    = VADC_W'(v);
        t.current_adc    = CADC_W'(c);
        t.run_switch     = run;
        t.time_ms        = tm;
        return t;
    endfunction

    // Time moves freely only on ticks that stop the stall timer; elsewhere the
    // total advance since the last such tick stays within the stall time.
    function automatic void stamp_time(inout t_tick t);
        bit          clears;
        int unsigned room;
        int unsigned adv;
        clears = t.run_switch &&
                 !(t.measured_speed <= st_speed && t.desired_speed > st_demand);
        if (clears) begin
            case ($urandom_range(0, 9))
                0:       now_ms = TIME_W'($urandom());
                1:       now_ms = 31'h7FFF_FFFF - TIME_W'($urandom_range(0, 3000));
                default: now_ms += TIME_W'($urandom_range(0, 3000));
            endcase
            used_ms = 0;
        end else begin
            room = st_time - used_ms;
            if ($urandom_range(0, 1) == 1) begin
                room = room / 8;
            end
            adv = $urandom_range(0, room);
            now_ms  += TIME_W'(adv);
            used_ms += adv;
        end
        t.time_ms = now_ms;
    endfunction

    function automatic t_tick random_tick();
        t_tick       t;
        int unsigned des;
        t.voltage_adc = ($urandom_range(0, 3) == 0) ? VADC_W'($urandom_range(0, 255))
                                                    : VADC_W'($urandom_range(0, 131));
        case ($urandom_range(0, 5))
            0:       t.current_adc = CADC_W'($urandom_range(0, 65535));
            1:       t.current_adc = '0;
            default: t.current_adc = CADC_W'($urandom_range(0, 19860));
        endcase
        t.run_switch = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                if (st_demand < 65535) begin
                    t.desired_speed  = SPD_W'($urandom_range(st_demand + 1, 65535));
                    t.measured_speed = SPD_W'($urandom_range(0, st_speed));
                end else begin
                    t.desired_speed  = SPD_W'($urandom());
                    t.measured_speed = SPD_W'($urandom());
                end
            end
            4: begin
                t.desired_speed  = '0;
                t.measured_speed = ($urandom_range(0, 1) == 1) ? '0 : SPD_W'($urandom());
            end
            5: begin
                t.desired_speed  = SPD_W'($urandom_range(1, 50));
                t.measured_speed = SPD_W'($urandom_range(0, 60));
            end
            6, 7: begin
                des              = $urandom_range(0, 65535);
                t.desired_speed  = SPD_W'(des);
                t.measured_speed = SPD_W'(des - $urandom_range(0, 300));
            end
            default: begin
                t.desired_speed  = SPD_W'($urandom());
                t.measured_speed = SPD_W'($urandom());
            end
        endcase
        stamp_time(t);
        return t;
    endfunction

    task automatic send_tick(input t_tick t);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_tdata  <= t;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input bit wr, input t_reg_idx idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic set_regs(input int unsigned mse, input int unsigned ssl,
                            input int unsigned sdm, input int unsigned stt);
        apb_xfer(1'b1, REG_MAX_SPEED_ERR, CFG_W'(mse));
        apb_xfer(1'b1, REG_STALL_SPEED,   CFG_W'(ssl));
        apb_xfer(1'b1, REG_STALL_DEMAND,  CFG_W'(sdm));
        apb_xfer(1'b1, REG_STALL_TIME,    CFG_W'(stt));
        apb_xfer(1'b0, REG_STALL_TIME,    '0);
        apb_xfer(1'b0, REG_STALL_DEMAND,  '0);
        apb_xfer(1'b0, REG_STALL_SPEED,   '0);
        apb_xfer(1'b0, REG_MAX_SPEED_ERR, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
        st_speed  = ssl;
        st_demand = sdm;
        st_time   = stt;
    endtask

    initial begin
        #10_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        st_speed  = RST_STALL_SPEED;
        st_demand = RST_STALL_DEMAND;
        st_time   = RST_STALL_TIME;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_tick(mk(0, 0, 0, 0, 1, 31'd0));
        send_tick(mk(0, 1, 0, 0, 1, 31'd10));
        send_tick(mk(65535, 0, 0, 0, 1, 31'd20));
        send_tick(mk(1, 0, 0, 0, 1, 31'd30));
        send_tick(mk(100, 200, 0, 0, 1, 31'd40));
        send_tick(mk(65535, 65535, 255, 65535, 1, 31'd50));
        send_tick(mk(1000, 990, 131, 0, 1, 31'd60));
        send_tick(mk(1000, 990, 132, 0, 1, 31'd70));
        send_tick(mk(1000, 990, 0, 19859, 1, 31'd80));
        send_tick(mk(1000, 990, 0, 19860, 1, 31'd90));
        send_tick(mk(1000, 990, 0, 0, 0, 31'd100));
        send_tick(mk(5000, 4000, 60, 1000, 1, 31'h7FFF_FF00));
        send_tick(mk(500, 5, 0, 0, 1, 31'h7FFF_FF80));
        send_tick(mk(500, 5, 0, 0, 0, 31'h7FFF_FFFF));
        send_tick(mk(500, 10, 0, 0, 1, 31'h0000_0100));
        send_tick(mk(500, 0, 0, 0, 1, 31'h0000_0368));
        send_tick(mk(21, 0, 20, 300, 1, 31'h0000_0368));
        send_tick(mk(20, 0, 0, 0, 1, 31'h0000_0380));
        send_tick(mk(500, 11, 0, 0, 1, 31'h0000_0400));
        send_tick(mk(30000, 20000, 100, 5000, 1, 31'h0000_0500));
        now_ms  = 31'h0000_0500;
        used_ms = 0;

        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            case (ph)
                0: set_regs(65535, 0, 0, 65535);
                1: set_regs(0, 65535, 65535, 0);
                3: set_regs(65535, 65535, $urandom_range(0, 200), 65535);
                default: set_regs($urandom_range(0, 65535), $urandom_range(0, 2000),
                                  $urandom_range(0, 3000), $urandom_range(0, 65535));
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            send_tick(mk(0, $urandom_range(0, 65535), 0, 0, 1, now_ms));
            used_ms = 0;
            repeat (110) send_tick(random_tick());
        end

        wait_drained();
        set_regs($urandom_range(0, 65535), 10, 20, $urandom_range(0, 300));
        no_idle = 1'b1;
        send_tick(mk(0, 0, 0, 0, 1, now_ms));
        for (int i = 0; i < 12; i++) begin
            now_ms += 31'd40;
            send_tick(mk($urandom_range(21, 65535), $urandom_range(0, 10),
                         $urandom_range(0, 131), $urandom_range(0, 19000), 1, now_ms));
        end
        used_ms = 0;
        repeat (30) send_tick(random_tick());

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

FILE: motor_pwm_duty_controller_core.f
design/mpdc_pkg.sv
design/mpdc_mul.sv
design/mpdc_div.sv
design/motor_pwm_duty_controller_core.sv
verif/mpdc_checker.sv
verif/tb_top.sv
